[rtl/core/dms_pkg.sv]
// ----------------------------------------------------------------------------
// dms_pkg
// Types and codes shared by the dosing station sequencer.
// ----------------------------------------------------------------------------
package dms_pkg;

	// event codes
	localparam logic [3:0] FN_TICK   = 4'd0;
	localparam logic [3:0] FN_START  = 4'd1;
	localparam logic [3:0] FN_STOP   = 4'd2;
	localparam logic [3:0] FN_RESET  = 4'd3;
	localparam logic [3:0] FN_TEMP   = 4'd4;
	localparam logic [3:0] FN_ESTOP  = 4'd5;
	localparam logic [3:0] FN_MODE   = 4'd6;
	localparam logic [3:0] FN_GUN    = 4'd7;
	localparam logic [3:0] FN_RECIPE = 4'd8;
	localparam logic [3:0] FN_ALARM  = 4'd9;

	// run modes
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_AUTO = 2'd1;
	localparam logic [1:0] MODE_MAN  = 2'd2;

	// fill stages
	localparam logic [2:0] STG_INIT    = 3'd0;
	localparam logic [2:0] STG_HEATING = 3'd1;
	localparam logic [2:0] STG_HEATED  = 3'd2;
	localparam logic [2:0] STG_SET     = 3'd3;
	localparam logic [2:0] STG_FILLING = 3'd4;
	localparam logic [2:0] STG_DONE    = 3'd5;
	localparam logic [2:0] STG_STOPPED = 3'd6;

	// alarm codes
	localparam logic [2:0] ALM_NONE    = 3'd0;
	localparam logic [2:0] ALM_TIMEOUT = 3'd1;
	localparam logic [2:0] ALM_PULSE   = 3'd2;
	localparam logic [2:0] ALM_MOTOR   = 3'd5;

	// register indexes
	localparam logic CFG_TARGET  = 1'b0;
	localparam logic CFG_TIMEOUT = 1'b1;

	localparam logic [7:0] TIMEOUT_RST = 8'd150;

	// valve bits
	localparam logic [11:0] V_AIR1 = 12'h001;
	localparam logic [11:0] V_AIR2 = 12'h002;
	localparam logic [11:0] V_AIR3 = 12'h004;
	localparam logic [11:0] V_AIR4 = 12'h008;
	localparam logic [11:0] V_AIR5 = 12'h010;
	localparam logic [11:0] V_GUN  = 12'h020;
	localparam logic [11:0] V_SOL1 = 12'h040;
	localparam logic [11:0] V_SOL2 = 12'h080;
	localparam logic [11:0] V_HEAT = 12'h200;
	localparam logic [11:0] V_PUMP = 12'h800;
	localparam logic [11:0] V_SHUTDOWN = V_SOL1 | V_PUMP | V_AIR1 | V_AIR2 | V_AIR3 |
		V_AIR4 | V_AIR5 | V_HEAT | V_GUN | V_SOL2;

	// lamp bits
	localparam logic [4:0] L_RED    = 5'h01;
	localparam logic [4:0] L_GREEN  = 5'h02;
	localparam logic [4:0] L_YELLOW = 5'h04;
	localparam logic [4:0] L_DONE   = 5'h08;
	localparam logic [4:0] L_BUZZ   = 5'h10;

	typedef struct packed {
		logic [3:0]  func;
		logic        level_active;
		logic        stop_held;
		logic        estop_held;
		logic        auto_selected;
		logic        heater_ready;
		logic [2:0]  fault_code;
		logic [15:0] pulse_count;
	} req_t;

	typedef struct packed {
		logic [11:0] valves;
		logic [4:0]  lamps;
		logic [1:0]  op_mode;
		logic [2:0]  fill_stage;
		logic [2:0]  alarm_code;
		logic [15:0] fills_done;
		logic        fill_active;
	} rsp_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [2:0]  stage;
		logic [11:0] valves;
		logic [4:0]  lamps;
		logic [2:0]  alarm;
		logic [7:0]  ticks;
		logic        timer_on;
		logic        stop_pending;
		logic [15:0] fill_total;
	} state_t;

	typedef struct packed {
		logic [15:0] target_pulses;
		logic [7:0]  timeout_ticks;
	} cfg_t;

endpackage

[rtl/core/dms_next.sv]
// ----------------------------------------------------------------------------
// dms_next
// Next-state logic: applies one event to the sequencer state.
// ----------------------------------------------------------------------------
module dms_next (
	input  dms_pkg::state_t st,
	input  dms_pkg::req_t   item,
	input  dms_pkg::cfg_t   cfg,
	output dms_pkg::state_t nx
);

	logic act;
	logic start_ok;

	assign act = item.level_active;

	always_comb begin
		nx       = st;
		start_ok = 1'b0;
		case (item.func)
			dms_pkg::FN_TICK: begin
				if (st.timer_on) begin
					if (st.ticks >= cfg.timeout_ticks) begin
						nx.timer_on = 1'b0;
						nx.lamps    = st.lamps | dms_pkg::L_RED | dms_pkg::L_BUZZ;
						nx.alarm    = dms_pkg::ALM_TIMEOUT;
						nx.stage    = dms_pkg::STG_SET;
					end else begin
						nx.ticks = st.ticks + 8'd1;
						if (item.pulse_count >= cfg.target_pulses) begin
							nx.fill_total = st.fill_total + 16'd1;
							nx.timer_on   = 1'b0;
							nx.stage      = dms_pkg::STG_DONE;
							nx.valves     = (st.valves & ~(dms_pkg::V_AIR4 | dms_pkg::V_GUN))
								| dms_pkg::V_SOL2;
							nx.lamps      = st.lamps | dms_pkg::L_DONE;
							// deferred stop lands once the fill is complete
							if (st.stop_pending) begin
								nx.lamps        = nx.lamps & ~(dms_pkg::L_GREEN | dms_pkg::L_DONE);
								nx.valves       = nx.valves & ~dms_pkg::V_SHUTDOWN;
								nx.stop_pending = 1'b0;
							end
						end
					end
				end
			end
			dms_pkg::FN_START: begin
				if (act && (st.lamps & dms_pkg::L_RED) == '0 && !item.stop_held &&
					!item.estop_held) begin
					start_ok = 1'b1;
					if (st.stage == dms_pkg::STG_STOPPED) begin
						if (item.auto_selected) begin
							nx.lamps = st.lamps & ~dms_pkg::L_RED;
							nx.mode  = dms_pkg::MODE_AUTO;
							nx.stage = dms_pkg::STG_INIT;
						end else begin
							start_ok = 1'b0;
						end
					end
					if (start_ok && nx.mode == dms_pkg::MODE_AUTO) begin
						nx.lamps  = nx.lamps | dms_pkg::L_GREEN;
						nx.valves = (st.valves | dms_pkg::V_SOL1 | dms_pkg::V_PUMP |
							dms_pkg::V_AIR1 | dms_pkg::V_AIR3 | dms_pkg::V_HEAT) &
							~(dms_pkg::V_AIR2 | dms_pkg::V_AIR4 | dms_pkg::V_AIR5);
						nx.stage  = dms_pkg::STG_HEATING;
					end
				end
			end
			dms_pkg::FN_STOP: begin
				if (act && st.mode == dms_pkg::MODE_AUTO) begin
					nx.mode  = dms_pkg::MODE_IDLE;
					nx.stage = dms_pkg::STG_STOPPED;
					nx.lamps = (st.lamps | dms_pkg::L_RED) & ~dms_pkg::L_GREEN;
					// a running fill finishes first, shutdown is deferred
					if (st.stage == dms_pkg::STG_FILLING) begin
						nx.stop_pending = 1'b1;
					end else begin
						nx.valves = st.valves & ~dms_pkg::V_SHUTDOWN;
						nx.lamps  = nx.lamps & ~dms_pkg::L_DONE;
					end
				end
			end
			dms_pkg::FN_RESET: begin
				if (act) begin
					nx.lamps = st.lamps & ~(dms_pkg::L_RED | dms_pkg::L_BUZZ);
					nx.alarm = dms_pkg::ALM_NONE;
				end
			end
			dms_pkg::FN_TEMP: begin
				if (act) begin
					nx.stage = dms_pkg::STG_HEATED;
				end
			end
			dms_pkg::FN_ESTOP: begin
				if (act && st.mode == dms_pkg::MODE_AUTO) begin
					nx.mode   = dms_pkg::MODE_IDLE;
					nx.stage  = dms_pkg::STG_STOPPED;
					nx.lamps  = (st.lamps | dms_pkg::L_RED) &
						~(dms_pkg::L_GREEN | dms_pkg::L_DONE);
					nx.valves = '0;
				end
			end
			dms_pkg::FN_MODE: begin
				if (item.auto_selected) begin
					nx.mode  = dms_pkg::MODE_AUTO;
					nx.lamps = st.lamps & ~dms_pkg::L_YELLOW;
				end else begin
					nx.mode  = dms_pkg::MODE_MAN;
					nx.lamps = st.lamps | dms_pkg::L_YELLOW;
				end
				nx.valves = '0;
			end
			dms_pkg::FN_GUN: begin
				if (act && (st.stage == dms_pkg::STG_SET || st.stage == dms_pkg::STG_DONE)) begin
					nx.stage    = dms_pkg::STG_FILLING;
					nx.lamps    = st.lamps & ~dms_pkg::L_DONE;
					nx.valves   = (st.valves | dms_pkg::V_AIR2 | dms_pkg::V_AIR4 |
						dms_pkg::V_GUN) & ~(dms_pkg::V_AIR3 | dms_pkg::V_SOL2);
					nx.ticks    = '0;
					nx.timer_on = 1'b1;
				end
			end
			dms_pkg::FN_RECIPE: begin
				if (item.heater_ready || st.stage == dms_pkg::STG_DONE) begin
					nx.stage = dms_pkg::STG_SET;
				end
			end
			dms_pkg::FN_ALARM: begin
				if (act && item.fault_code >= dms_pkg::ALM_PULSE &&
					item.fault_code <= dms_pkg::ALM_MOTOR) begin
					nx.lamps = st.lamps | dms_pkg::L_RED | dms_pkg::L_BUZZ;
					nx.alarm = item.fault_code;
				end
			end
			default: begin
				nx = st;
			end
		endcase
	end

endmodule

[rtl/core/dosing_machine_sequencer_top.sv]
// ----------------------------------------------------------------------------
// dosing_machine_sequencer_top
// Event-driven sequencer for a heated liquid-dosing station.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (req_valid/req_stall/req): one event per transaction, either
//    a 100 ms tick with the flow-meter pulse count or a button/sensor event.
//  - rsp channel (rsp_valid/rsp_stall/rsp): exactly one transaction per event,
//    carrying the full output image (valves, lamps, mode, stage, alarm,
//    completed-fill count, fill timer running) after that event.
//  - cfg port: cfg_we with cfg_idx 0 writes target_pulses (cfg_data[15:0]),
//    cfg_idx 1 writes timeout_ticks (cfg_data[7:0]). Write only when idle.
// Path: an accepted request goes into the input register, then one pass of
//   next-state logic writes the state and response registers; a stalled
//   response holds the event in the input register.
// Throughput: one event per cycle while rsp is not stalled; the state update
//   is a single short combinational pass, so events stream back to back.
// Stall: while rsp is stalled, one more event may sit in the input register;
//   req_stall rises only when that register is full and cannot drain.
// Reset: arst_n clears the state (idle mode, init stage, everything off,
//   timeout 150 ticks, target 0) and empties both channels.
// ----------------------------------------------------------------------------
module dosing_machine_sequencer_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  dms_pkg::req_t   req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output dms_pkg::rsp_t   rsp,
	input  logic            cfg_we,
	input  logic            cfg_idx,
	input  logic [15:0]     cfg_data
);

	// input register
	logic            valid_s1;
	dms_pkg::req_t   item_s1;

	// architectural state and configuration
	dms_pkg::state_t st_q;
	dms_pkg::state_t st_nx;
	dms_pkg::cfg_t   cfg_q;

	// response register
	logic            rsp_valid_q;
	dms_pkg::rsp_t   rsp_q;

	logic            advance;
	logic            accept;

	// s1 drains whenever the response slot is empty or being taken
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_pulses <= '0;
			cfg_q.timeout_ticks <= dms_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				dms_pkg::CFG_TARGET:  cfg_q.target_pulses <= cfg_data;
				dms_pkg::CFG_TIMEOUT: cfg_q.timeout_ticks <= cfg_data[7:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	dms_next u_next (
		.st   (st_q),
		.item (item_s1),
		.cfg  (cfg_q),
		.nx   (st_nx)
	);

	// state commits together with the response image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{mode: dms_pkg::MODE_IDLE, stage: dms_pkg::STG_INIT,
				alarm: dms_pkg::ALM_NONE, default: '0};
		end else if (advance) begin
			st_q <= st_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.valves      <= st_nx.valves;
			rsp_q.lamps       <= st_nx.lamps;
			rsp_q.op_mode     <= st_nx.mode;
			rsp_q.fill_stage  <= st_nx.stage;
			rsp_q.alarm_code  <= st_nx.alarm;
			rsp_q.fills_done  <= st_nx.fill_total;
			rsp_q.fill_active <= st_nx.timer_on;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && rsp_valid_q && rsp_stall))
		else $error("req stalled while the pipeline could drain");

	a_advance_fills_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid_q)
		else $error("event advanced without a response");

	a_rsp_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.fill_active == st_q.timer_on &&
			rsp_q.fills_done == st_q.fill_total && rsp_q.fill_stage == st_q.stage))
		else $error("response image out of step with state");

	a_rsp_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_stall && !advance) |=> !rsp_valid_q)
		else $error("response repeated after it was taken");

endmodule
